>>> rtl/adq_pkg.sv
`timescale 1ns / 1ps

package adq_pkg;

    // Default number of slots in the deque.
    localparam int DEPTH_DEFAULT = 16;

    // Width of one stored word.
    localparam int WORD_W = 32;

    // Width of the occupancy field in a result beat.
    localparam int OCC_W = 5;

    typedef enum logic [1:0] {
        FN_PUSH_REAR  = 2'd0,
        FN_PUSH_FRONT = 2'd1,
        FN_POP_FRONT  = 2'd2,
        FN_POP_REAR   = 2'd3
    } adq_func_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } adq_status_t;

    // Per-cell command: write the pushed word, take the lower neighbour's word,
    // or drive the held word onto the read bus.
    typedef struct packed {
        logic load;
        logic shift;
        logic read;
    } adq_cell_ctl_t;

endpackage

>>> rtl/array_double_ended_queue_core.sv
`timescale 1ns / 1ps

// Channel   Direction  tdata (lowest bit first)                     tuser
// s_axis    in         push_value[31:0], zero pad [39:32]            func[1:0]
// m_axis    out        pop_value[31:0], status[33:32],               -
//                      occupancy[38:34], now_empty[39]
//
// One beat is taken per cycle; its result is registered and offered on m_axis
// in the next cycle, so the block sustains one operation every clock while m_axis is not stalled.
// A front push at slot zero moves the whole row of cells up by one in that
// same cycle, each cell taking its lower neighbour's word.
// Reset clears the indices, the count and the output valid flag; the slot words
// are not cleared. s_axis stalls only while a result waits and m_axis is stalled.

module array_double_ended_queue_core
#(
    parameter int DEPTH = adq_pkg::DEPTH_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // push_value[31:0], zero pad [39:32]
    input  logic [1:0]  s_axis_tuser,   // func[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // pop_value, status, occupancy, now_empty
);
    import adq_pkg::*;

    // Slot index width and the width of counters that must also hold DEPTH.
    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    // The rear index is kept one above the slot it names, so an empty deque at
    // reset has a rear of zero rather than minus one.
    logic [CW-1:0] head_reg, head_next;
    logic [CW-1:0] rear_reg, rear_next;
    logic [CW-1:0] count_reg, count_next;

    logic              out_valid_reg;
    logic [WORD_W-1:0] pop_value_reg;
    adq_status_t       status_reg;
    logic [OCC_W-1:0]  occupancy_reg;
    logic              now_empty_reg;

    logic        accept;
    adq_func_t   func;
    logic        is_empty;
    logic        is_full;
    logic [CW-1:0] head_dec;
    logic [CW-1:0] rear_dec;

    logic              wr_en;
    logic [IW-1:0]     wr_idx;
    logic              shift_en;
    logic              rd_en;
    logic [IW-1:0]     rd_idx;
    adq_status_t       status_c;
    logic [WORD_W-1:0] popped;
    logic [CW+OCC_W-1:0] count_wide;

    logic [WORD_W-1:0] cell_word [DEPTH];
    logic [WORD_W-1:0] cell_read [DEPTH];

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign func          = adq_func_t'(s_axis_tuser);

    // Empty when the rear has fallen to the head; full once the rear reaches
    // the top slot, whatever room is left below the head.
    assign is_empty = rear_reg <= head_reg;
    assign is_full  = rear_reg == DEPTH_C;
    assign head_dec = head_reg - 1'b1;
    assign rear_dec = rear_reg - 1'b1;

    always_comb
    begin
        head_next  = head_reg;
        rear_next  = rear_reg;
        count_next = count_reg;
        wr_en      = 1'b0;
        wr_idx     = '0;
        shift_en   = 1'b0;
        rd_en      = 1'b0;
        rd_idx     = '0;
        status_c   = ST_OK;
        if (accept)
        begin
            case (func)
                FN_PUSH_REAR:
                begin
                    if (is_full)
                    begin
                        status_c = ST_FULL;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        wr_idx     = rear_reg[IW-1:0];
                        rear_next  = rear_reg + 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                end
                FN_PUSH_FRONT:
                begin
                    if (is_full)
                    begin
                        status_c = ST_FULL;
                    end
                    else
                    begin
                        count_next = count_reg + 1'b1;
                        if (is_empty)
                        begin
                            // The word lands at the head slot itself.
                            wr_en     = 1'b1;
                            wr_idx    = head_reg[IW-1:0];
                            rear_next = head_reg + 1'b1;
                        end
                        else if (head_reg == '0)
                        begin
                            // No room below: the row moves up and the bottom
                            // cell takes the pushed word.
                            shift_en  = 1'b1;
                            rear_next = rear_reg + 1'b1;
                        end
                        else
                        begin
                            wr_en     = 1'b1;
                            wr_idx    = head_dec[IW-1:0];
                            head_next = head_dec;
                        end
                    end
                end
                FN_POP_FRONT:
                begin
                    if (is_empty)
                    begin
                        status_c = ST_EMPTY;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_idx     = head_reg[IW-1:0];
                        head_next  = head_reg + 1'b1;
                        count_next = count_reg - 1'b1;
                    end
                end
                FN_POP_REAR:
                begin
                    if (is_empty)
                    begin
                        status_c = ST_EMPTY;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_idx     = rear_dec[IW-1:0];
                        rear_next  = rear_dec;
                        count_next = count_reg - 1'b1;
                    end
                end
                default:
                begin
                    status_c = ST_OK;
                end
            endcase
        end
    end

    // Row of cells; each one decodes its own slot number from the shared write and read indices.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        localparam logic [IW-1:0] CELL_IDX = IW'(i);
        adq_cell_ctl_t ctl;

        assign ctl.load  = wr_en && (wr_idx == CELL_IDX);
        assign ctl.shift = shift_en;
        assign ctl.read  = rd_en && (rd_idx == CELL_IDX);

        if (i == 0)
        begin : g_bottom
            adq_cell u_cell
            (
                .clk       (clk),
                .ctl       (ctl),
                .push_word (s_axis_tdata[WORD_W-1:0]),
                .prev_word (s_axis_tdata[WORD_W-1:0]),
                .word      (cell_word[i]),
                .read_word (cell_read[i])
            );
        end
        else
        begin : g_upper
            adq_cell u_cell
            (
                .clk       (clk),
                .ctl       (ctl),
                .push_word (s_axis_tdata[WORD_W-1:0]),
                .prev_word (cell_word[i-1]),
                .word      (cell_word[i]),
                .read_word (cell_read[i])
            );
        end
    end

    // At most one cell drives a non-zero word, so the read bus is an OR.
    always_comb
    begin
        popped = '0;
        for (int k = 0; k < DEPTH; k++)
        begin
            popped = popped | cell_read[k];
        end
    end

    assign count_wide = {{OCC_W{1'b0}}, count_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            rear_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg  <= head_next;
            rear_reg  <= rear_next;
            count_reg <= count_next;
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload; loaded only when a beat is taken.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pop_value_reg <= popped;
            status_reg    <= status_c;
            occupancy_reg <= count_wide[OCC_W-1:0];
            now_empty_reg <= rear_next <= head_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {now_empty_reg, occupancy_reg, status_reg, pop_value_reg};

`ifndef SYNTHESIS
    // The count always matches the span between the two indices.
    a_count_span: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == CW'(rear_reg - head_reg))
        else $error("stored count disagrees with index span");

    // The head never passes the rear.
    a_head_order: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg <= rear_reg)
        else $error("head index beyond rear index");

    // A pending full result means the rear still sits at the top slot.
    a_full_top: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg == ST_FULL) |-> rear_reg == DEPTH_C)
        else $error("full status reported below the top slot");

    // After a front shift the rear has moved up by one and the head is at slot zero.
    a_shift_cause: assert property (@(posedge clk) disable iff (!rst_n)
        shift_en |=> (rear_reg == $past(rear_reg) + 1'b1) && (head_reg == '0))
        else $error("front shift did not advance the rear");
`endif

endmodule

>>> rtl/adq_cell.sv
`timescale 1ns / 1ps

module adq_cell
(
    input  logic                        clk,
    input  adq_pkg::adq_cell_ctl_t      ctl,
    input  logic [adq_pkg::WORD_W-1:0]  push_word,
    input  logic [adq_pkg::WORD_W-1:0]  prev_word,
    output logic [adq_pkg::WORD_W-1:0]  word,
    output logic [adq_pkg::WORD_W-1:0]  read_word
);
    import adq_pkg::*;

    logic [WORD_W-1:0] word_reg;

    // A shift moves the word of the neighbour below into this cell; the
    // bottom cell sees the pushed word as its neighbour.
    always_ff @(posedge clk)
    begin
        if (ctl.shift)
        begin
            word_reg <= prev_word;
        end
        else if (ctl.load)
        begin
            word_reg <= push_word;
        end
    end

    assign word      = word_reg;
    assign read_word = ctl.read ? word_reg : '0;

endmodule
